/* rtl/core/tcat_pkg.sv */
package tcat_pkg;

   localparam int SAMPLE_W = 10;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int TENTH_W  = 4;
   localparam int TICKS_W  = 6;
   localparam int GAIN_W   = 4;
   localparam int OFFSET_W = 10;
   localparam int TEMP_W   = 12;

   localparam int MAG_W = SAMPLE_W + GAIN_W;
   localparam int NUM_W = MAG_W + 1;

   localparam int TENTHS_PER_SEC = 10;
   localparam int SEC_PER_MIN    = 60;
   localparam int MIN_PER_HOUR   = 60;
   localparam int HOURS_PER_DAY  = 24;
   localparam int TEMP_DIV       = 10;

   localparam int AVG_DEPTH_DEF = 10;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [TICKS_W-1:0]  TICKS_RESET  = 6'd40;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd4;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd500;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET = 2'd2;

   typedef struct packed {
      logic [HOUR_W-1:0]   hours;
      logic [MINUTE_W-1:0] minutes;
      logic [SECOND_W-1:0] seconds;
      logic [TENTH_W-1:0]  tenths;
      logic                upd;
      logic [SAMPLE_W-1:0] sample;
   } tick_type;

endpackage

/* rtl/core/tcat_front.sv */
module tcat_front #(
   parameter int AVG_DEPTH = tcat_pkg::AVG_DEPTH_DEF,
   parameter int SLOT_W    = $clog2(AVG_DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [tcat_pkg::SAMPLE_W-1:0]  sample,
   input  logic [tcat_pkg::TICKS_W-1:0]   ticks_per_tenth,
   output tcat_pkg::tick_type             item,
   output logic [SLOT_W-1:0]              slot
);

   logic [tcat_pkg::TICKS_W-1:0]  prescale_ff, prescale_in;
   logic [tcat_pkg::TENTH_W-1:0]  tenth_ff, tenth_in;
   logic [tcat_pkg::SECOND_W-1:0] second_ff, second_in;
   logic [tcat_pkg::MINUTE_W-1:0] minute_ff, minute_in;
   logic [tcat_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [tcat_pkg::TICKS_W:0]    count_inc;
   logic                          advance;
   logic                          upd;

   always_comb begin
      count_inc   = {1'b0, prescale_ff} + 1'b1;
      advance     = count_inc >= {1'b0, ticks_per_tenth};
      prescale_in = count_inc[tcat_pkg::TICKS_W-1:0];
      tenth_in    = tenth_ff;
      second_in   = second_ff;
      minute_in   = minute_ff;
      hour_in     = hour_ff;
      slot_in     = slot_ff;
      upd         = 1'b0;
      if (advance) begin
         prescale_in = '0;
         if (tenth_ff == tcat_pkg::TENTH_W'(tcat_pkg::TENTHS_PER_SEC - 1)) begin
            tenth_in = '0;
            upd      = 1'b1;
            if (second_ff == tcat_pkg::SECOND_W'(tcat_pkg::SEC_PER_MIN - 1)) begin
               second_in = '0;
               slot_in   = '0;
               if (minute_ff == tcat_pkg::MINUTE_W'(tcat_pkg::MIN_PER_HOUR - 1)) begin
                  minute_in = '0;
                  if (hour_ff == tcat_pkg::HOUR_W'(tcat_pkg::HOURS_PER_DAY - 1)) begin
                     hour_in = '0;
                  end else begin
                     hour_in = hour_ff + 1'b1;
                  end
               end else begin
                  minute_in = minute_ff + 1'b1;
               end
            end else begin
               second_in = second_ff + 1'b1;
               if (slot_ff == SLOT_W'(AVG_DEPTH - 1)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end else begin
            tenth_in = tenth_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         tenth_ff    <= '0;
         second_ff   <= '0;
         minute_ff   <= '0;
         hour_ff     <= '0;
         slot_ff     <= '0;
      end else if (accept) begin
         prescale_ff <= prescale_in;
         tenth_ff    <= tenth_in;
         second_ff   <= second_in;
         minute_ff   <= minute_in;
         hour_ff     <= hour_in;
         slot_ff     <= slot_in;
      end
   end

   always_comb begin
      item.hours   = hour_in;
      item.minutes = minute_in;
      item.seconds = second_in;
      item.tenths  = tenth_in;
      item.upd     = upd;
      item.sample  = sample;
      slot         = slot_in;
   end

endmodule

/* rtl/core/tcat_queue.sv */
module tcat_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tcat_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;
   assign head_data = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/core/tcat_cdiv.sv */
module tcat_cdiv #(
   parameter int WIDTH   = 16,
   parameter int DIVISOR = 10
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] x,
   output logic [WIDTH-1:0] q
);

   // reciprocal estimate is low by at most one; one compare fixes it
   localparam int MUL_W = WIDTH - $clog2(DIVISOR) + 1;
   localparam logic [MUL_W-1:0] MUL = MUL_W'((64'd1 << WIDTH) / DIVISOR);

   logic [WIDTH+MUL_W-1:0] prod_ff;
   logic [WIDTH-1:0]       x_ff;
   logic [WIDTH-1:0]       q_ff, q_in;
   logic [WIDTH-1:0]       q0, qd, rem;

   always_comb begin
      q0   = WIDTH'(prod_ff[WIDTH+MUL_W-1:WIDTH]);
      qd   = WIDTH'(q0 * DIVISOR);
      rem  = x_ff - qd;
      q_in = (rem >= WIDTH'(DIVISOR)) ? q0 + 1'b1 : q0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= x * MUL;
         x_ff    <= x;
         q_ff    <= q_in;
      end
   end

   assign q = q_ff;

endmodule

/* rtl/core/tcat_back.sv */
module tcat_back #(
   parameter int AVG_DEPTH = tcat_pkg::AVG_DEPTH_DEF,
   parameter int SLOT_W    = $clog2(AVG_DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tcat_pkg::tick_type             head_item,
   input  logic [SLOT_W-1:0]              head_slot,
   input  logic                           head_valid,
   output logic                           pop,
   input  logic [tcat_pkg::GAIN_W-1:0]    temp_gain,
   input  logic [tcat_pkg::OFFSET_W-1:0]  temp_offset,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output tcat_pkg::tick_type             rsp_item,
   output logic [tcat_pkg::TEMP_W-1:0]    rsp_temp
);

   localparam int STAGES = 7;
   localparam int SUM_W  = $clog2(AVG_DEPTH * ((1 << tcat_pkg::SAMPLE_W) - 1) + 1);

   logic                          en;
   tcat_pkg::tick_type            item_ff [STAGES];
   logic [STAGES-1:0]             vld_ff;

   logic [tcat_pkg::SAMPLE_W-1:0] ring_mem [AVG_DEPTH];
   logic [AVG_DEPTH-1:0]          ring_vld_ff;
   logic [tcat_pkg::SAMPLE_W-1:0] rd_ff;
   logic                          rd_vld_ff;
   logic [SLOT_W-1:0]             slot0_ff;

   logic [SUM_W-1:0]              sum_ff, sum_in, s1_sum_ff;
   logic [tcat_pkg::SAMPLE_W-1:0] old_sample;
   logic                          store;

   logic [SUM_W-1:0]              avg_q;
   logic [tcat_pkg::MAG_W-1:0]    scaled;
   logic signed [tcat_pkg::NUM_W-1:0] num_in, num_ff;
   logic                          neg;
   logic [tcat_pkg::NUM_W-1:0]    num_abs;
   logic [tcat_pkg::MAG_W-1:0]    mag, mag_q;
   logic                          neg5_ff, neg6_ff;
   logic [tcat_pkg::TEMP_W-1:0]   temp_new;
   logic [tcat_pkg::TEMP_W-1:0]   last_temp_ff;

   logic                          rsp_valid_ff;
   tcat_pkg::tick_type            rsp_item_ff;
   logic [tcat_pkg::TEMP_W-1:0]   rsp_temp_ff;

   assign en  = !rsp_valid_ff || rsp_ready;
   assign pop = en && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], head_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= head_item;
         slot0_ff   <= head_slot;
         for (int k = 1; k < STAGES; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
      end
   end

   // ring read on dequeue; the slot is written back at stage 0
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= ring_mem[head_slot];
      end
      if (store) begin
         ring_mem[slot0_ff] <= item_ff[0].sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (pop) begin
            rd_vld_ff <= ring_vld_ff[head_slot];
         end
         if (store) begin
            ring_vld_ff[slot0_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      store      = en && vld_ff[0] && item_ff[0].upd;
      old_sample = rd_vld_ff ? rd_ff : '0;
      sum_in     = sum_ff - SUM_W'(old_sample) + SUM_W'(item_ff[0].sample);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (store) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sum_ff <= sum_in;
      end
   end

   tcat_cdiv #(
      .WIDTH   (SUM_W),
      .DIVISOR (AVG_DEPTH)
   ) u_avg_div (
      .clock (clock),
      .en    (en),
      .x     (s1_sum_ff),
      .q     (avg_q)
   );

   always_comb begin
      scaled = tcat_pkg::MAG_W'(avg_q[tcat_pkg::SAMPLE_W-1:0] * temp_gain);
      num_in = $signed({1'b0, scaled}) - $signed(tcat_pkg::NUM_W'(temp_offset));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         neg5_ff <= neg;
         neg6_ff <= neg5_ff;
      end
   end

   always_comb begin
      neg     = num_ff[tcat_pkg::NUM_W-1];
      num_abs = neg ? tcat_pkg::NUM_W'(-num_ff) : tcat_pkg::NUM_W'(num_ff);
      mag     = num_abs[tcat_pkg::MAG_W-1:0];
   end

   tcat_cdiv #(
      .WIDTH   (tcat_pkg::MAG_W),
      .DIVISOR (tcat_pkg::TEMP_DIV)
   ) u_temp_div (
      .clock (clock),
      .en    (en),
      .x     (mag),
      .q     (mag_q)
   );

   assign temp_new = neg6_ff ? tcat_pkg::TEMP_W'(-mag_q) : tcat_pkg::TEMP_W'(mag_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_temp_ff <= '0;
      end else if (en && vld_ff[STAGES-1] && item_ff[STAGES-1].upd) begin
         last_temp_ff <= temp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_item_ff <= item_ff[STAGES-1];
         rsp_temp_ff <= item_ff[STAGES-1].upd ? temp_new : last_temp_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign rsp_temp  = rsp_temp_ff;

endmodule

/* rtl/core/tick_clock_with_averaged_temperature_unit.sv */
// A request passes through the queue, the back pipeline and the response register.
// Throughput: one request per cycle while the queue is not full; the back pipeline stalls as a whole only
// while the response register is held.
// Reset (synchronous): clears the time chain, sample ring valid bits, running sum,
// last temperature, the queue and the pipeline; registers return to 40, 4, 500.
module tick_clock_with_averaged_temperature_unit #(
   parameter int AVG_DEPTH = tcat_pkg::AVG_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // adc_sample[9:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // hours, minutes, seconds, tenths, temperature
   output logic [0:0]  rsp_tuser,   // temp_updated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tcat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcat_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int SLOT_W = $clog2(AVG_DEPTH);
   localparam int Q_W    = $bits(tcat_pkg::tick_type) + SLOT_W;

   logic [tcat_pkg::TICKS_W-1:0]  ticks_ff;
   logic [tcat_pkg::GAIN_W-1:0]   gain_ff;
   logic [tcat_pkg::OFFSET_W-1:0] offset_ff;

   logic                          accept;
   tcat_pkg::tick_type            push_item, head_item, rsp_item;
   logic [SLOT_W-1:0]             push_slot, head_slot;
   logic [Q_W-1:0]                head_data;
   logic                          q_full, q_empty, pop;
   logic [tcat_pkg::TEMP_W-1:0]   rsp_temp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= tcat_pkg::TICKS_RESET;
         gain_ff   <= tcat_pkg::GAIN_RESET;
         offset_ff <= tcat_pkg::OFFSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tcat_pkg::CSR_TICKS:  ticks_ff  <= csr_data[tcat_pkg::TICKS_W-1:0];
            tcat_pkg::CSR_GAIN:   gain_ff   <= csr_data[tcat_pkg::GAIN_W-1:0];
            tcat_pkg::CSR_OFFSET: offset_ff <= csr_data[tcat_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   tcat_front #(
      .AVG_DEPTH (AVG_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .sample          (req_tdata[tcat_pkg::SAMPLE_W-1:0]),
      .ticks_per_tenth (ticks_ff),
      .item            (push_item),
      .slot            (push_slot)
   );

   tcat_queue #(
      .WIDTH (Q_W),
      .DEPTH (tcat_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({push_item, push_slot}),
      .pop       (pop),
      .head_data (head_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign head_item = head_data[Q_W-1:SLOT_W];
   assign head_slot = head_data[SLOT_W-1:0];

   tcat_back #(
      .AVG_DEPTH (AVG_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_item   (head_item),
      .head_slot   (head_slot),
      .head_valid  (!q_empty),
      .pop         (pop),
      .temp_gain   (gain_ff),
      .temp_offset (offset_ff),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_item    (rsp_item),
      .rsp_temp    (rsp_temp)
   );

   assign rsp_tdata = {7'd0, rsp_temp, rsp_item.tenths, rsp_item.seconds,
                       rsp_item.minutes, rsp_item.hours};
   assign rsp_tuser = rsp_item.upd;

endmodule
